[rtl/core/cis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types, constants and the byte class table of the identifier
// character sanitiser.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 4;

  localparam logic [CharW-1:0] Underscore = 8'h5F;
  localparam logic [PosW-1:0]  PosSat     = 4'd11;
  localparam logic [PosW-1:0]  OperLo     = 4'd8;
  localparam logic [PosW-1:0]  OperHi     = 4'd10;
  localparam logic [PosW-1:0]  PrefixLen  = 4'd8;

  // Permission class bits
  typedef struct packed {
    logic oper;
    logic tmpl;
    logic first;
    logic after;
  } cis_cls_t;

  // Per-name context seen by the classifier
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            in_template;
    logic            prefix_match;
  } cis_ctx_t;

  // State update requests from the classifier
  typedef struct packed {
    logic open_br;
    logic close_br;
    logic prefix_miss;
  } cis_upd_t;

  // Expected byte of "operator" at a given position
  function automatic logic [CharW-1:0] prefix_char(input logic [2:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      3'd0:    c = "o";
      3'd1:    c = "p";
      3'd2:    c = "e";
      3'd3:    c = "r";
      3'd4:    c = "a";
      3'd5:    c = "t";
      3'd6:    c = "o";
      3'd7:    c = "r";
      default: c = "o";
    endcase
    return c;
  endfunction

  // Permission classes of a byte below 128
  function automatic cis_cls_t byte_classes(input logic [CharW-1:0] c);
    cis_cls_t cls;
    cls = '0;
    if (c inside {["0":"9"]}) begin
      cls = '{oper: 1'b1, tmpl: 1'b1, first: 1'b0, after: 1'b1};
    end else begin
      case (c)
        "_":
          cls = '{oper: 1'b1, tmpl: 1'b1, first: 1'b1, after: 1'b1};
        "*", "(", ")", "[", "]":
          cls = '{oper: 1'b1, tmpl: 1'b1, first: 1'b0, after: 1'b0};
        ":", ",":
          cls = '{oper: 1'b0, tmpl: 1'b1, first: 1'b0, after: 1'b0};
        "&", "+", "-", "|", "=", "!", "/", "%", "^":
          cls = '{oper: 1'b1, tmpl: 1'b0, first: 1'b0, after: 1'b0};
        "~":
          cls = '{oper: 1'b1, tmpl: 1'b1, first: 1'b1, after: 1'b0};
        default:
          cls = '0;
      endcase
    end
    return cls;
  endfunction

endpackage

[rtl/core/cis_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cis_classify
// Judges one byte against the current name context: keeps it or replaces
// it with an underscore, and reports bracket and prefix events.
// ----------------------------------------------------------------------------
module cis_classify (
  input  logic [cis_pkg::CharW-1:0] char_i,
  input  cis_pkg::cis_ctx_t         ctx_i,
  output logic [cis_pkg::CharW-1:0] char_o,
  output cis_pkg::cis_upd_t         upd_o
);

  cis_pkg::cis_cls_t cls;
  logic              is_letter;
  logic              is_open;
  logic              is_close;
  logic              pos_first;
  logic              pos_oper;
  logic              allowed;

  // Decode the byte
  always_comb begin
    is_letter = (char_i inside {["A":"Z"], ["a":"z"]});
    is_open   = (char_i == "<");
    is_close  = (char_i == ">");
    cls       = cis_pkg::byte_classes(char_i);
  end

  // Check permission classes against the position and nesting
  always_comb begin
    pos_first = (ctx_i.pos == '0);
    pos_oper  = (ctx_i.pos >= cis_pkg::OperLo) && (ctx_i.pos <= cis_pkg::OperHi);
    allowed   = (cls.after && !pos_first) ||
                (cls.first && pos_first) ||
                (cls.tmpl && ctx_i.in_template) ||
                (cls.oper && pos_oper && ctx_i.prefix_match);
    if (is_letter || is_open || is_close) begin
      char_o = char_i;
    end else if (char_i[cis_pkg::CharW-1]) begin
      char_o = cis_pkg::Underscore;
    end else begin
      char_o = allowed ? char_i : cis_pkg::Underscore;
    end
  end

  // Report state events
  always_comb begin
    upd_o.open_br     = is_open;
    upd_o.close_br    = is_close;
    upd_o.prefix_miss = (ctx_i.pos < cis_pkg::PrefixLen) &&
                        (char_i != cis_pkg::prefix_char(ctx_i.pos[2:0]));
  end

endmodule

[rtl/core/cpp_identifier_char_sanitizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_identifier_char_sanitizer
// Byte-wise cleaner for C++ symbol names.
// ----------------------------------------------------------------------------
// One request carries one byte of a name and a last-byte flag; one result
// carries the kept byte or an underscore and a copy of the flag. Each byte is
// judged combinationally and lands in a one-deep result register, so a new
// byte is taken every cycle while the result side keeps up. Letters and angle
// brackets always pass, bytes of 128 and above always become an underscore,
// and other bytes pass by their position in the name, the template nesting
// depth and whether the name began with "operator". Nesting depth saturates
// at MAX_TEMPLATE_DEPTH and floors at zero. All per-name state returns to
// reset after the last byte.
// ----------------------------------------------------------------------------
module cpp_identifier_char_sanitizer #(
  parameter int unsigned MAX_TEMPLATE_DEPTH = 255
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [cis_pkg::CharW-1:0] char_in_i,
  input  logic                      end_of_name_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [cis_pkg::CharW-1:0] char_out_o,
  output logic                      name_done_o
);

  localparam int unsigned DepthW = $clog2(MAX_TEMPLATE_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_TEMPLATE_DEPTH);

  logic [DepthW-1:0]          depth_q, depth_d;
  logic [cis_pkg::PosW-1:0]   pos_q, pos_d;
  logic                       match_q, match_d;
  logic                       out_valid_q, out_valid_d;
  logic [cis_pkg::CharW-1:0]  char_q;
  logic                       done_q;
  logic                       accept;
  cis_pkg::cis_ctx_t          ctx;
  cis_pkg::cis_upd_t          upd;
  logic [cis_pkg::CharW-1:0]  char_res;

  // Take a request whenever the result register is empty or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign ctx = '{pos: pos_q, in_template: (depth_q != '0), prefix_match: match_q};

  cis_classify u_classify (
    .char_i (char_in_i),
    .ctx_i  (ctx),
    .char_o (char_res),
    .upd_o  (upd)
  );

  // Advance per-name state; drop it back to reset after the last byte
  always_comb begin
    depth_d = depth_q;
    pos_d   = pos_q;
    match_d = match_q;
    if (accept) begin
      if (end_of_name_i) begin
        depth_d = '0;
        pos_d   = '0;
        match_d = 1'b1;
      end else begin
        if (upd.open_br && (depth_q < DepthMax)) begin
          depth_d = depth_q + DepthW'(1);
        end else if (upd.close_br && (depth_q != '0)) begin
          depth_d = depth_q - DepthW'(1);
        end
        if (pos_q < cis_pkg::PosSat) begin
          pos_d = pos_q + cis_pkg::PosW'(1);
        end
        match_d = match_q && !upd.prefix_miss;
      end
    end
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      pos_q       <= '0;
      match_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      pos_q       <= pos_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_res;
      done_q <= end_of_name_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign name_done_o = done_q;

endmodule

[rtl/core/cis_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cis_checker
// Port-level checks of the identifier character sanitiser.
// ----------------------------------------------------------------------------
module cis_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [cis_pkg::CharW-1:0] char_in_i,
  input logic                      end_of_name_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [cis_pkg::CharW-1:0] char_out_o,
  input logic                      name_done_o
);

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(char_out_o) && $stable(name_done_o)))
    else $error("stalled result changed");

  // Every accepted request yields a result with its last-byte flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=>
      (out_valid_o && (name_done_o == $past(end_of_name_i))))
    else $error("result missing or flag mismatch");

  // Letters always pass unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o &&
     (((char_in_i >= "A") && (char_in_i <= "Z")) ||
      ((char_in_i >= "a") && (char_in_i <= "z")))) |=>
      (char_out_o == $past(char_in_i)))
    else $error("letter altered");

  // Bytes of 128 and above always become an underscore
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && char_in_i[cis_pkg::CharW-1]) |=>
      (char_out_o == cis_pkg::Underscore))
    else $error("high byte not replaced");

endmodule

bind cpp_identifier_char_sanitizer cis_checker u_cis_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .char_in_i     (char_in_i),
  .end_of_name_i (end_of_name_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .char_out_o    (char_out_o),
  .name_done_o   (name_done_o)
);

[dv/cpp_identifier_char_sanitizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_identifier_char_sanitizer_test
// Self-checking testbench for the identifier character sanitiser.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes runs first, followed by random symbol
// names. Most names are well formed: "operator" names with operator tails,
// names whose operator prefix breaks, short prefixes, and template-heavy names
// with one very deep nesting run. The rest are raw byte noise. Each request is
// fed to a local sanitiser model, and every result is compared in order
// against the model, or against the value typed in the table. Valid and
// ready idle at random in the first two of three phases, and the sender
// drains all pending results between phases.
// ----------------------------------------------------------------------------
module cpp_identifier_char_sanitizer_test;

  localparam int unsigned MaxDepth   = 255;
  localparam int unsigned RandBytes  = 1700;
  localparam int unsigned DirRows    = 25;
  localparam logic [63:0] OpWord     = "operator";
  localparam string       Specials   = "_0123456789*()[]:,&+-|=!/%^~<>aZ.$ ";
  localparam string       OperTail   = "+-*/%^&|=!~()[]<>_0123456789";

  typedef struct packed {
    logic [cis_pkg::CharW-1:0] ch;
    logic                      done;
  } san_byte_t;

  // Directed request with an optional hand-written expected byte
  typedef struct packed {
    logic [cis_pkg::CharW-1:0] ch;
    logic                      last;
    logic                      typed;
    logic [cis_pkg::CharW-1:0] want;
  } dir_row_t;

  typedef enum int unsigned {
    NameOperator,
    NameBrokenOp,
    NameShortOp,
    NameTemplate,
    NameNoise,
    NameDeep
  } name_kind_e;

  localparam dir_row_t DirTable [DirRows] = '{
    // a name opening with letters, then the byte extremes
    '{"A",    1'b0, 1'b1, "A"},
    '{"z",    1'b0, 1'b1, "z"},
    '{8'hFF,  1'b0, 1'b1, cis_pkg::Underscore},
    '{8'h80,  1'b0, 1'b1, cis_pkg::Underscore},
    '{8'h00,  1'b0, 1'b1, cis_pkg::Underscore},
    // closing bracket with no template open
    '{">",    1'b0, 1'b1, ">"},
    '{":",    1'b0, 1'b0, 8'h00},
    '{"<",    1'b0, 1'b1, "<"},
    '{":",    1'b0, 1'b0, 8'h00},
    '{">",    1'b1, 1'b1, ">"},
    // tilde first, digit after it
    '{"~",    1'b0, 1'b0, 8'h00},
    '{"7",    1'b1, 1'b0, 8'h00},
    // digit as a one-byte name
    '{"9",    1'b1, 1'b0, 8'h00},
    // operator name running past the operator window
    '{"o",    1'b0, 1'b1, "o"},
    '{"p",    1'b0, 1'b1, "p"},
    '{"e",    1'b0, 1'b1, "e"},
    '{"r",    1'b0, 1'b1, "r"},
    '{"a",    1'b0, 1'b1, "a"},
    '{"t",    1'b0, 1'b1, "t"},
    '{"o",    1'b0, 1'b1, "o"},
    '{"r",    1'b0, 1'b1, "r"},
    '{"+",    1'b0, 1'b0, 8'h00},
    '{"=",    1'b0, 1'b0, 8'h00},
    '{"&",    1'b0, 1'b0, 8'h00},
    '{"-",    1'b1, 1'b0, 8'h00}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      byte_valid;
  logic                      byte_ready;
  logic [cis_pkg::CharW-1:0] byte_in;
  logic                      byte_last;
  logic                      res_valid;
  logic                      res_ready = 1'b0;
  logic [cis_pkg::CharW-1:0] res_char;
  logic                      res_done;

  // Sanitiser model state
  int unsigned               tmpl_depth;
  int unsigned               name_pos;
  logic                      prefix_ok;

  san_byte_t                 pending_q [$];
  san_byte_t                 head_exp;
  logic [cis_pkg::CharW-1:0] name_buf [$];

  int unsigned               send_idle_pct;
  int unsigned               recv_idle_pct;
  int unsigned               failures;
  int unsigned               bytes_sent;
  int unsigned               names_sent;
  int unsigned               results_seen;
  int unsigned               bytes_replaced;
  int unsigned               depth_peak;

  cpp_identifier_char_sanitizer #(
    .MAX_TEMPLATE_DEPTH(MaxDepth)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (byte_valid),
    .in_ready_o   (byte_ready),
    .char_in_i    (byte_in),
    .end_of_name_i(byte_last),
    .out_valid_o  (res_valid),
    .out_ready_i  (res_ready),
    .char_out_o   (res_char),
    .name_done_o  (res_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("cpp_identifier_char_sanitizer test failed");
    $finish;
  end

  // Clear per-name state
  function automatic void clear_name();
    tmpl_depth = 0;
    name_pos   = 0;
    prefix_ok  = 1'b1;
  endfunction

  // Judge one byte against the current name state, then advance that state
  function automatic san_byte_t sanitise_byte(input logic [cis_pkg::CharW-1:0] c,
                                              input logic last);
    logic        digit;
    logic        ok;
    int unsigned p;
    san_byte_t   r;
    p     = name_pos;
    digit = (c >= "0") && (c <= "9");
    if (p < cis_pkg::PrefixLen && c != OpWord[8*(7-p) +: 8]) prefix_ok = 1'b0;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      r.ch = c;
    end else if (c == "<") begin
      if (tmpl_depth < MaxDepth) tmpl_depth++;
      r.ch = c;
    end else if (c == ">") begin
      if (tmpl_depth > 0) tmpl_depth--;
      r.ch = c;
    end else if (c[7]) begin
      r.ch = cis_pkg::Underscore;
    end else begin
      ok = ((digit || c == "_") && p > 0) ||
           ((c == "_" || c == "~") && p == 0) ||
           ((digit || c inside {"_", "*", "(", ")", "[", "]", ":", ",", "~"}) &&
            tmpl_depth > 0) ||
           ((digit || c inside {"_", "*", "(", ")", "[", "]", "&", "+", "-", "|",
                                "=", "!", "/", "%", "^", "~"}) &&
            p >= cis_pkg::OperLo && p <= cis_pkg::OperHi && prefix_ok);
      r.ch = ok ? c : cis_pkg::Underscore;
    end
    if (p < cis_pkg::PosSat) name_pos = p + 1;
    if (tmpl_depth > depth_peak) depth_peak = tmpl_depth;
    r.done = last;
    if (last) clear_name();
    return r;
  endfunction

  function automatic logic [cis_pkg::CharW-1:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [cis_pkg::CharW-1:0] rand_char();
    return $urandom_range(0, 1) ? pick_from(Specials)
                                : cis_pkg::CharW'($urandom_range(0, 255));
  endfunction

  // Append one byte to the name buffer
  function automatic void add_name_byte(input logic [cis_pkg::CharW-1:0] c);
    name_buf = {name_buf, c};
  endfunction

  // Offer one request, with a random gap ahead of it; return once accepted
  task automatic send_byte(input logic [cis_pkg::CharW-1:0] c, input logic last,
                           input logic typed, input logic [cis_pkg::CharW-1:0] want);
    san_byte_t e;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    e = sanitise_byte(c, last);
    if (typed) e.ch = want;
    if (e.ch == cis_pkg::Underscore && c != cis_pkg::Underscore) bytes_replaced++;
    pending_q = {pending_q, e};
    byte_valid <= 1'b1;
    byte_in    <= c;
    byte_last  <= last;
    do @(posedge clk); while (!byte_ready);
    @(negedge clk);
    bytes_sent++;
    if (last) names_sent++;
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending_q.size() != 0);
  endtask

  // Fill the name buffer with one random name of the given shape
  task automatic build_name(input name_kind_e kind);
    int unsigned n;
    int unsigned k;
    name_buf.delete();
    case (kind)
      NameOperator, NameBrokenOp: begin
        for (int i = 0; i < 8; i++) add_name_byte(OpWord[8*(7-i) +: 8]);
        if (kind == NameBrokenOp) name_buf[$urandom_range(0, 7)] = rand_char();
        n = $urandom_range(kind == NameBrokenOp ? 0 : 1, 5);
        for (int i = 0; i < n; i++)
          add_name_byte($urandom_range(0, 3) != 0 ? pick_from(OperTail) : rand_char());
      end
      NameShortOp: begin
        k = $urandom_range(1, 7);
        for (int i = 0; i < k; i++) add_name_byte(OpWord[8*(7-i) +: 8]);
      end
      NameTemplate: begin
        n = $urandom_range(2, 20);
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(0, 9);
          if (k < 2)       add_name_byte(cis_pkg::CharW'("a" + $urandom_range(0, 25)));
          else if (k < 4)  add_name_byte("<");
          else if (k == 4) add_name_byte(">");
          else             add_name_byte(pick_from(Specials));
        end
      end
      NameNoise: begin
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
          add_name_byte(cis_pkg::CharW'($urandom_range(0, 255)));
      end
      default: begin
        // nest up to or past the ceiling, use it, then unwind part of the way
        n = $urandom_range(MaxDepth - 3, MaxDepth + 6);
        for (int i = 0; i < n; i++) add_name_byte("<");
        for (int i = 0; i < 4; i++) add_name_byte(pick_from(Specials));
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) add_name_byte(">");
        add_name_byte(pick_from(Specials));
      end
    endcase
  endtask

  task automatic send_name();
    for (int i = 0; i < name_buf.size(); i++)
      send_byte(name_buf[i], i == name_buf.size() - 1, 1'b0, 8'h00);
  endtask

  // Receiver side: drop ready at random
  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each result against the oldest pending expectation
  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: char_out %02h name_done %0b", res_char, res_done);
        failures++;
      end else begin
        head_exp = pending_q.pop_front();
        if (res_char !== head_exp.ch) begin
          $error("char_out: expected %02h, got %02h", head_exp.ch, res_char);
          failures++;
        end
        if (res_done !== head_exp.done) begin
          $error("name_done: expected %0b, got %0b", head_exp.done, res_done);
          failures++;
        end
        results_seen++;
      end
    end
  end

  initial begin
    int unsigned phase_start;
    int unsigned k;
    name_kind_e  kind;
    rst_n          = 1'b0;
    byte_valid     = 1'b0;
    byte_in        = '0;
    byte_last      = 1'b0;
    send_idle_pct  = 16;
    recv_idle_pct  = 46;
    failures       = 0;
    bytes_sent     = 0;
    names_sent     = 0;
    results_seen   = 0;
    bytes_replaced = 0;
    depth_peak     = 0;
    clear_name();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < DirRows; i++)
      send_byte(DirTable[i].ch, DirTable[i].last, DirTable[i].typed, DirTable[i].want);
    drain();

    // Random names in three phases, idling at random in the first two
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 46 : 0;
      recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 16 : 0;
      phase_start   = bytes_sent;
      while (bytes_sent - phase_start < RandBytes / 3) begin
        k = $urandom_range(0, 9);
        if (ph == 0 && bytes_sent == phase_start) kind = NameDeep;
        else if (k < 3)  kind = NameOperator;
        else if (k == 3) kind = NameBrokenOp;
        else if (k == 4) kind = NameShortOp;
        else if (k < 8)  kind = NameTemplate;
        else             kind = NameNoise;
        build_name(kind);
        send_name();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    failures += pending_q.size();
    $display("Sent %0d bytes in %0d names; %0d results checked, %0d replaced.",
             bytes_sent, names_sent, results_seen, bytes_replaced);
    $display("Deepest template nesting reached: %0d of %0d.", depth_peak, MaxDepth);
    if (failures == 0) begin
      $display("cpp_identifier_char_sanitizer test passed");
    end else begin
      $display("cpp_identifier_char_sanitizer test failed");
    end
    $finish;
  end

endmodule
